// ===== hdl/rc_capture_hex_mixer_esc_pwm_core_defines.svh =====
// ----------------------------------------------------------------------------
// RC capture hex mixer ESC PWM core - assertion macros
// Shared concurrent assertion forms used by the core top level.
// ----------------------------------------------------------------------------
`ifndef RC_CAPTURE_HEX_MIXER_ESC_PWM_CORE_DEFINES_SVH
`define RC_CAPTURE_HEX_MIXER_ESC_PWM_CORE_DEFINES_SVH

// Same-cycle implication, disabled during reset
`define RCHM_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("rchm: assertion failed");

// Next-cycle implication, disabled during reset
`define RCHM_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("rchm: assertion failed");

`endif

// ===== hdl/rchm_pkg.sv =====
// ----------------------------------------------------------------------------
// RC capture hex mixer package
// Widths, reset values, register codes and shared types of the core.
// ----------------------------------------------------------------------------
package rchm_pkg;

	// Default pulse counter width
	localparam int CNT_BITS_DEF = 16;

	// Field widths
	localparam int CH_W    = 12;
	localparam int MOT_W   = 12;
	localparam int MAX_W   = 11;
	localparam int FC_W    = 16;
	localparam int OFS_W   = CH_W + 1;
	localparam int SUM_W   = 16;
	localparam int N_CH    = 4;
	localparam int N_MOT   = 6;
	localparam int ADDR_W  = 5;
	localparam int DATA_W  = 32;

	// Queue between front and back
	localparam int Q_DEPTH = 2;
	localparam int QPTR_W  = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
	localparam int QCNT_W  = $clog2(Q_DEPTH + 1);

	// Register reset values
	localparam logic [FC_W-1:0]  FRAME_PERIOD_RST = FC_W'(4000);
	localparam logic [CH_W-1:0]  STICK_CENTER_RST = CH_W'(1500);
	localparam logic [CH_W-1:0]  ARM_THRESH_RST   = CH_W'(1050);
	localparam logic [MOT_W-1:0] STOP_PULSE_RST   = MOT_W'(1000);
	localparam logic [CH_W-1:0]  MIN_PULSE_RST    = CH_W'(1100);
	localparam logic [MAX_W-1:0] MAX_PULSE_RST    = MAX_W'(2000);
	localparam logic [CH_W-1:0]  INPUT_MIN_RST    = CH_W'(1000);
	localparam logic [CH_W-1:0]  INPUT_MAX_RST    = CH_W'(2000);

	// Register index codes
	typedef enum logic [2:0] {
		REG_FRAME_PERIOD = 3'd0,
		REG_STICK_CENTER = 3'd1,
		REG_ARM_THRESH   = 3'd2,
		REG_STOP_PULSE   = 3'd3,
		REG_MIN_PULSE    = 3'd4,
		REG_MAX_PULSE    = 3'd5,
		REG_INPUT_MIN    = 3'd6,
		REG_INPUT_MAX    = 3'd7
	} reg_idx_t;

	// Configuration register set
	typedef struct packed {
		logic [FC_W-1:0]  frame_period;
		logic [CH_W-1:0]  stick_center;
		logic [CH_W-1:0]  arm_threshold;
		logic [MOT_W-1:0] stop_pulse;
		logic [CH_W-1:0]  min_pulse;
		logic [MAX_W-1:0] max_pulse;
		logic [CH_W-1:0]  input_min;
		logic [CH_W-1:0]  input_max;
	} rchm_cfg_t;

	// One classified tick from front to back
	typedef struct packed {
		logic [N_CH-1:0][CH_W-1:0] chan;
		logic [FC_W-1:0]           fc;
		logic                      start;
	} rchm_entry_t;

	// Queue status seen by the top level
	typedef struct packed {
		logic              push;
		logic              pop;
		logic [QCNT_W-1:0] count;
	} rchm_qstat_t;

endpackage

// ===== hdl/rc_capture_hex_mixer_esc_pwm_core.sv =====
// Path: an accepted tick goes into the tick queue, then into stage 1, then into the output register.
// Throughput: one tick per clock; the front stalls only when the two-entry
// tick queue is full, which happens only while the result side is stalled.
// Reset: arst_n clears all control state at once, loads register defaults,
// zeroes pulse capture and frame count, and sets all motor widths to the stop
// width; there is no clearing pass, so a tick is taken right after reset.
// ----------------------------------------------------------------------------
// RC capture hex mixer ESC PWM core
// Receiver pulse capture, hexacopter motor mixing and ESC pulse generation.
// ----------------------------------------------------------------------------
`include "rc_capture_hex_mixer_esc_pwm_core_defines.svh"

module rc_capture_hex_mixer_esc_pwm_core import rchm_pkg::*; #(
	parameter int COUNTER_BITS = CNT_BITS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic              pready,
	input  logic              tick_valid,
	output logic              tick_ready,
	input  logic [N_CH-1:0]   receiver_pins,
	output logic              result_valid,
	input  logic              result_ready,
	output logic [N_MOT-1:0]  motor_pins,
	output logic              frame_start
);

	rchm_cfg_t   cfg;
	rchm_entry_t wr_entry;
	rchm_entry_t rd_entry;
	rchm_qstat_t qstat;
	logic        q_push;
	logic        q_pop;
	logic        q_full;
	logic        q_empty;

	rchm_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	rchm_front #(
		.COUNTER_BITS (COUNTER_BITS)
	) u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.tick_valid    (tick_valid),
		.tick_ready    (tick_ready),
		.receiver_pins (receiver_pins),
		.cfg           (cfg),
		.q_full        (q_full),
		.q_push        (q_push),
		.q_entry       (wr_entry)
	);

	rchm_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.wr_entry (wr_entry),
		.pop      (q_pop),
		.rd_entry (rd_entry),
		.full     (q_full),
		.empty    (q_empty),
		.stat     (qstat)
	);

	rchm_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg),
		.q_empty      (q_empty),
		.q_entry      (rd_entry),
		.q_pop        (q_pop),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.motor_pins   (motor_pins),
		.frame_start  (frame_start)
	);

	// Queue bookkeeping checks
	`RCHM_ASSERT_IMP(a_q_bound, clk, arst_n, 1'b1, qstat.count <= QCNT_W'(Q_DEPTH))
	`RCHM_ASSERT_IMP(a_q_pop_nonempty, clk, arst_n, qstat.pop, qstat.count != '0)
	`RCHM_ASSERT_NXT(a_q_grow, clk, arst_n, qstat.push && !qstat.pop, qstat.count == $past(qstat.count) + QCNT_W'(1))
	`RCHM_ASSERT_NXT(a_q_shrink, clk, arst_n, qstat.pop && !qstat.push, qstat.count == $past(qstat.count) - QCNT_W'(1))

endmodule

// ===== hdl/rchm_regs.sv =====
// ----------------------------------------------------------------------------
// RC capture hex mixer configuration registers
// APB-style register file with fixed reset values and read back.
// ----------------------------------------------------------------------------
module rchm_regs import rchm_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic              pready,
	output rchm_cfg_t         cfg
);

	rchm_cfg_t cfg_q;
	reg_idx_t  idx;
	logic      wr_en;

	assign pready = 1'b1;
	assign idx    = reg_idx_t'(paddr[ADDR_W-1:2]);
	assign wr_en  = psel & penable & pwrite & pready;
	assign cfg    = cfg_q;

	// Write one register per completed request
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.frame_period  <= FRAME_PERIOD_RST;
			cfg_q.stick_center  <= STICK_CENTER_RST;
			cfg_q.arm_threshold <= ARM_THRESH_RST;
			cfg_q.stop_pulse    <= STOP_PULSE_RST;
			cfg_q.min_pulse     <= MIN_PULSE_RST;
			cfg_q.max_pulse     <= MAX_PULSE_RST;
			cfg_q.input_min     <= INPUT_MIN_RST;
			cfg_q.input_max     <= INPUT_MAX_RST;
		end else if (wr_en) begin
			unique case (idx)
				REG_FRAME_PERIOD: cfg_q.frame_period  <= pwdata[FC_W-1:0];
				REG_STICK_CENTER: cfg_q.stick_center  <= pwdata[CH_W-1:0];
				REG_ARM_THRESH:   cfg_q.arm_threshold <= pwdata[CH_W-1:0];
				REG_STOP_PULSE:   cfg_q.stop_pulse    <= pwdata[MOT_W-1:0];
				REG_MIN_PULSE:    cfg_q.min_pulse     <= pwdata[CH_W-1:0];
				REG_MAX_PULSE:    cfg_q.max_pulse     <= pwdata[MAX_W-1:0];
				REG_INPUT_MIN:    cfg_q.input_min     <= pwdata[CH_W-1:0];
				REG_INPUT_MAX:    cfg_q.input_max     <= pwdata[CH_W-1:0];
				default: ;
			endcase
		end
	end

	// Read back the addressed register
	always_comb begin
		prdata = '0;
		unique case (idx)
			REG_FRAME_PERIOD: prdata = DATA_W'(cfg_q.frame_period);
			REG_STICK_CENTER: prdata = DATA_W'(cfg_q.stick_center);
			REG_ARM_THRESH:   prdata = DATA_W'(cfg_q.arm_threshold);
			REG_STOP_PULSE:   prdata = DATA_W'(cfg_q.stop_pulse);
			REG_MIN_PULSE:    prdata = DATA_W'(cfg_q.min_pulse);
			REG_MAX_PULSE:    prdata = DATA_W'(cfg_q.max_pulse);
			REG_INPUT_MIN:    prdata = DATA_W'(cfg_q.input_min);
			REG_INPUT_MAX:    prdata = DATA_W'(cfg_q.input_max);
			default:          prdata = '0;
		endcase
	end

endmodule

// ===== hdl/rchm_front.sv =====
// ----------------------------------------------------------------------------
// RC capture hex mixer front end
// Accepts pin ticks, times receiver pulses, clamps widths and tags frames.
// ----------------------------------------------------------------------------
module rchm_front import rchm_pkg::*; #(
	parameter int COUNTER_BITS = CNT_BITS_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            tick_valid,
	output logic            tick_ready,
	input  logic [N_CH-1:0] receiver_pins,
	input  rchm_cfg_t       cfg,
	input  logic            q_full,
	output logic            q_push,
	output rchm_entry_t     q_entry
);

	logic [N_CH-1:0]                   seen_q;
	logic [N_CH-1:0][COUNTER_BITS-1:0] cnt_q;
	logic [N_CH-1:0][COUNTER_BITS-1:0] width_q;
	logic [FC_W-1:0]                   fc_q;

	logic [N_CH-1:0]                   seen_d;
	logic [N_CH-1:0][COUNTER_BITS-1:0] cnt_d;
	logic [N_CH-1:0][COUNTER_BITS-1:0] width_d;
	logic [N_CH-1:0][CH_W-1:0]         clamped;
	logic [FC_W:0]                     fc_inc;
	logic [FC_W-1:0]                   fc_d;
	logic                              accept;

	assign tick_ready = !q_full;
	assign accept     = tick_valid & tick_ready;
	assign q_push     = accept;

	// Time each channel pulse, saturate, then clamp the latest width
	always_comb begin
		for (int i = 0; i < N_CH; i++) begin
			seen_d[i]  = seen_q[i];
			cnt_d[i]   = cnt_q[i];
			width_d[i] = width_q[i];
			if (seen_q[i]) begin
				if (cnt_q[i] != {COUNTER_BITS{1'b1}}) begin
					cnt_d[i] = cnt_q[i] + COUNTER_BITS'(1);
				end
				if (!receiver_pins[i]) begin
					width_d[i] = cnt_d[i];
					seen_d[i]  = 1'b0;
				end
			end else if (receiver_pins[i]) begin
				seen_d[i] = 1'b1;
				cnt_d[i]  = '0;
			end
			if (width_d[i] < COUNTER_BITS'(cfg.input_min)) begin
				clamped[i] = cfg.input_min;
			end else if (width_d[i] > COUNTER_BITS'(cfg.input_max)) begin
				clamped[i] = cfg.input_max;
			end else begin
				clamped[i] = width_d[i][CH_W-1:0];
			end
		end
	end

	// Advance the frame counter, wrap at the frame period
	always_comb begin
		fc_inc = {1'b0, fc_q} + (FC_W+1)'(1);
		if (fc_inc >= {1'b0, cfg.frame_period}) begin
			fc_d = '0;
		end else begin
			fc_d = fc_inc[FC_W-1:0];
		end
	end

	assign q_entry.chan  = clamped;
	assign q_entry.fc    = fc_q;
	assign q_entry.start = (fc_q == '0);

	// Commit capture and frame state on each accepted tick
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q  <= '0;
			cnt_q   <= '0;
			width_q <= '0;
			fc_q    <= '0;
		end else if (accept) begin
			seen_q  <= seen_d;
			cnt_q   <= cnt_d;
			width_q <= width_d;
			fc_q    <= fc_d;
		end
	end

endmodule

// ===== hdl/rchm_fifo.sv =====
// ----------------------------------------------------------------------------
// RC capture hex mixer tick queue
// Short queue of classified ticks between the front and the back end.
// ----------------------------------------------------------------------------
module rchm_fifo import rchm_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	input  rchm_entry_t wr_entry,
	input  logic        pop,
	output rchm_entry_t rd_entry,
	output logic        full,
	output logic        empty,
	output rchm_qstat_t stat
);

	rchm_entry_t       mem_q [Q_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;

	assign full       = (count_q == QCNT_W'(Q_DEPTH));
	assign empty      = (count_q == '0);
	assign rd_entry   = mem_q[rd_ptr_q];
	assign stat.push  = push;
	assign stat.pop   = pop;
	assign stat.count = count_q;

	// Store the incoming request
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_entry;
		end
	end

	// Advance pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_q + QPTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_q + QPTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + QCNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - QCNT_W'(1);
			end
		end
	end

endmodule

// ===== hdl/rchm_back.sv =====
// ----------------------------------------------------------------------------
// RC capture hex mixer back end
// Mixes stick offsets into six motor widths at frame start, drives the ESC
// pins and holds each result in an output register.
// ----------------------------------------------------------------------------
module rchm_back import rchm_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  rchm_cfg_t        cfg,
	input  logic             q_empty,
	input  rchm_entry_t      q_entry,
	output logic             q_pop,
	output logic             result_valid,
	input  logic             result_ready,
	output logic [N_MOT-1:0] motor_pins,
	output logic             frame_start
);

	logic                    v_s1;
	logic signed [OFS_W-1:0] r_s1;
	logic signed [OFS_W-1:0] p_s1;
	logic signed [OFS_W-1:0] y_s1;
	logic [CH_W-1:0]         t_s1;
	logic [FC_W-1:0]         fc_s1;
	logic                    start_s1;

	logic [N_MOT-1:0][MOT_W-1:0] motor_width_q;
	logic                        out_v_q;
	logic [N_MOT-1:0]            pins_q;
	logic                        start_q;

	logic                           move_out;
	logic                           load_s1;
	logic signed [SUM_W-1:0]        re, pe, ye, te, min_s, max_s;
	logic signed [N_MOT-1:0][SUM_W-1:0] mix;
	logic signed [SUM_W-1:0]        lim;
	logic [N_MOT-1:0][MOT_W-1:0]    width_new;
	logic [N_MOT-1:0]               pins_new;
	logic                           disarm;

	assign move_out = v_s1 && (!out_v_q || result_ready);
	assign load_s1  = !q_empty && (!v_s1 || move_out);
	assign q_pop    = load_s1;

	// Stage 1: take stick offsets from center
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (load_s1) begin
			v_s1 <= 1'b1;
		end else if (move_out) begin
			v_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_s1) begin
			r_s1     <= $signed({1'b0, q_entry.chan[0]}) - $signed({1'b0, cfg.stick_center});
			p_s1     <= $signed({1'b0, q_entry.chan[1]}) - $signed({1'b0, cfg.stick_center});
			t_s1     <= q_entry.chan[2];
			y_s1     <= $signed({1'b0, q_entry.chan[3]}) - $signed({1'b0, cfg.stick_center});
			fc_s1    <= q_entry.fc;
			start_s1 <= q_entry.start;
		end
	end

	// Mix, clamp to the armed range, compare against the frame count
	always_comb begin
		re     = SUM_W'(r_s1);
		pe     = SUM_W'(p_s1);
		ye     = SUM_W'(y_s1);
		te     = $signed(SUM_W'(t_s1));
		min_s  = $signed(SUM_W'(cfg.min_pulse));
		max_s  = $signed(SUM_W'(cfg.max_pulse));
		disarm = (t_s1 < cfg.arm_threshold);
		mix[0] = te + ye + pe + re;
		mix[1] = te - ye + pe + re;
		mix[2] = te + ye + re;
		mix[3] = te - ye - pe - re;
		mix[4] = te + ye - pe - re;
		mix[5] = te - ye - re;
		for (int i = 0; i < N_MOT; i++) begin
			lim = mix[i];
			if (lim < min_s) begin
				lim = min_s;
			end
			if (lim > max_s) begin
				lim = max_s;
			end
			if (!start_s1) begin
				width_new[i] = motor_width_q[i];
			end else if (disarm) begin
				width_new[i] = cfg.stop_pulse;
			end else begin
				width_new[i] = lim[MOT_W-1:0];
			end
			pins_new[i] = (fc_s1 < FC_W'(width_new[i]));
		end
	end

	// Hold motor widths across the frame
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			motor_width_q <= {N_MOT{STOP_PULSE_RST}};
		end else if (move_out && start_s1) begin
			motor_width_q <= width_new;
		end
	end

	// Output register: hold the result until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (move_out) begin
			out_v_q <= 1'b1;
		end else if (result_ready) begin
			out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (move_out) begin
			pins_q  <= pins_new;
			start_q <= start_s1;
		end
	end

	assign result_valid = out_v_q;
	assign motor_pins   = pins_q;
	assign frame_start  = start_q;

endmodule
